// ===== sv/isq_pkg.sv =====
// shared constants, types and address helper for the indexed sequence store
package isq_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the stream words
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_SWAP   = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_BOUNDS = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_SWAP_B,
        S_SWAP_WR_A,
        S_SWAP_WR_B,
        S_SHIFT,
        S_DONE
    } state_t;

    // one command word as taken from the input stream
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position_b;
        logic [POS_W-1:0]   position_a;
        logic [CMD_W-1:0]   cmd;
    } req_t;

    // one result word handed to the output stage
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] read_value;
        status_t            status;
    } res_t;

    // physical ram address of a logical position in the circular buffer
    function automatic addr_t phys(input addr_t head, input cnt_t pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

// ===== sv/isq_ram.sv =====
// generic simple dual port ram with registered read, read-first on collision
module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/isq_ctrl.sv =====
// command sequencer: head pointer, word count and read-modify-write of the ram
module isq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  isq_pkg::req_t  req,
    output logic           res_valid,
    input  logic           res_ready,
    output isq_pkg::res_t  res,
    output logic           ram_we,
    output isq_pkg::addr_t ram_wr_addr,
    output isq_pkg::word_t ram_wr_data,
    output isq_pkg::addr_t ram_rd_addr,
    input  isq_pkg::word_t ram_rd_data
);

    import isq_pkg::*;

    state_t  state_reg,  state_next;
    addr_t   head_reg,   head_next;
    cnt_t    held_reg,   held_next;
    cnt_t    pa_reg,     pa_next;
    cnt_t    pb_reg,     pb_next;
    cnt_t    idx_reg,    idx_next;
    word_t   tmp_reg,    tmp_next;
    word_t   rdval_reg,  rdval_next;
    status_t status_reg, status_next;

    logic             full;
    logic             pa_ok;
    logic             pb_ok;
    cnt_t             pa_cnt;
    cnt_t             pb_cnt;
    logic [SUM_W-1:0] pa_plus1;
    logic [SUM_W-1:0] idx_plus2;

    // bounds checks on the incoming word
    assign full      = (held_reg == CNT_W'(DEPTH));
    assign pa_ok     = CMP_W'(req.position_a) < CMP_W'(held_reg);
    assign pb_ok     = CMP_W'(req.position_b) < CMP_W'(held_reg);
    assign pa_cnt    = CNT_W'(req.position_a);
    assign pb_cnt    = CNT_W'(req.position_b);
    assign pa_plus1  = SUM_W'(pa_cnt) + SUM_W'(1);
    assign idx_plus2 = SUM_W'(idx_reg) + SUM_W'(2);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            held_reg  <= held_next;
        end
    end

    // per-command working registers
    always_ff @(posedge clk)
    begin
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        idx_reg    <= idx_next;
        tmp_reg    <= tmp_next;
        rdval_reg  <= rdval_next;
        status_reg <= status_next;
    end

    // next state, ram access and result
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        held_next   = held_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        idx_next    = idx_reg;
        tmp_next    = tmp_reg;
        rdval_next  = rdval_reg;
        status_next = status_reg;

        req_ready   = 1'b0;
        res_valid   = 1'b0;
        ram_we      = 1'b0;
        ram_wr_addr = phys(head_reg, idx_reg);
        ram_wr_data = ram_rd_data;
        ram_rd_addr = phys(head_reg, pa_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready   = 1'b1;
                ram_rd_addr = phys(head_reg, pa_cnt);
                if (req_valid)
                begin
                    pa_next     = pa_cnt;
                    pb_next     = pb_cnt;
                    rdval_next  = '0;
                    status_next = STAT_OK;
                    state_next  = S_DONE;
                    unique case (req.cmd)
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_wr_addr = phys(head_reg, held_reg);
                                ram_wr_data = word_t'(req.value);
                                held_next   = held_reg + CNT_W'(1);
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                head_next   = (head_reg == '0) ? ADDR_W'(DEPTH - 1)
                                                               : head_reg - ADDR_W'(1);
                                ram_we      = 1'b1;
                                ram_wr_addr = head_next;
                                ram_wr_data = word_t'(req.value);
                                held_next   = held_reg + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE:
                        begin
                            ram_rd_addr = phys(head_reg, pa_plus1[CNT_W-1:0]);
                            if (!pa_ok)
                            begin
                                status_next = STAT_BOUNDS;
                            end
                            else if (pa_cnt == '0)
                            begin
                                // removing the head only moves the pointer
                                head_next = phys(head_reg, CNT_W'(1));
                                held_next = held_reg - CNT_W'(1);
                            end
                            else if (pa_plus1 >= SUM_W'(held_reg))
                            begin
                                held_next = held_reg - CNT_W'(1);
                            end
                            else
                            begin
                                idx_next   = pa_cnt;
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_SWAP:
                        begin
                            if (!pa_ok || !pb_ok)
                            begin
                                status_next = STAT_BOUNDS;
                            end
                            else
                            begin
                                state_next = S_SWAP_B;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!pa_ok)
                            begin
                                status_next = STAT_BOUNDS;
                            end
                            else
                            begin
                                state_next = S_READ_WAIT;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_BOUNDS;
                        end
                    endcase
                end
            end

            S_READ_WAIT:
            begin
                rdval_next = ram_rd_data;
                state_next = S_DONE;
            end

            // first swap word arrives, fetch the second
            S_SWAP_B:
            begin
                tmp_next    = ram_rd_data;
                ram_rd_addr = phys(head_reg, pb_reg);
                state_next  = S_SWAP_WR_A;
            end

            S_SWAP_WR_A:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = phys(head_reg, pa_reg);
                ram_wr_data = ram_rd_data;
                state_next  = S_SWAP_WR_B;
            end

            S_SWAP_WR_B:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = phys(head_reg, pb_reg);
                ram_wr_data = tmp_reg;
                state_next  = S_DONE;
            end

            // close the gap: write idx from idx+1 while fetching idx+2
            S_SHIFT:
            begin
                ram_we      = 1'b1;
                ram_wr_addr = phys(head_reg, idx_reg);
                ram_wr_data = ram_rd_data;
                ram_rd_addr = phys(head_reg, idx_plus2[CNT_W-1:0]);
                idx_next    = idx_reg + CNT_W'(1);
                if (idx_plus2 >= SUM_W'(held_reg))
                begin
                    held_next  = held_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word
    assign res.status     = status_reg;
    assign res.read_value = VALUE_W'(rdval_reg);
    assign res.count      = COUNT_W'(held_reg);

endmodule

// ===== sv/indexed_sequence_store.sv =====
// top level of the indexed sequence store: stream ports, sequencer, ram, output register
//
// Usage: one command word enters on s_axis, one result word leaves on m_axis per command.
// The sequence lives in a circular buffer in a one-port-read, one-port-write ram; a head
// pointer and a word count sit in flip-flops, so insert at the head needs no shifting.
// Steps per command, from acceptance to the next possible acceptance: append, insert
// at head, remove at position 0 or at the tail and any rejected command go straight
// to the result; a read waits for one ram read; a swap does two reads, then uses the
// ram write port twice; a remove in the middle moves one ram word per cycle. The
// result word is loaded into the output register as the command finishes, and
// m_axis_tvalid is driven from that register. Only one command is in the sequencer
// at a time, so ram accesses of consecutive commands never overlap. The result sits
// in an output register: the next command is accepted while it waits, and a stalled
// receiver only holds the sequencer once a second result is ready. Reset empties the
// store at once (count zero, head at entry 0); the ram needs no clearing since words
// at positions beyond the count are never used in a result.
module indexed_sequence_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], position_a[7:3], position_b[12:8], value[44:13], zero pad[47:45]
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], read_value[33:2], count[39:34]
    output logic [39:0] m_axis_tdata
);

    import isq_pkg::*;

    req_t  req;
    res_t  res;
    logic  res_valid;
    logic  res_ready;
    logic  ram_we;
    addr_t ram_wr_addr;
    word_t ram_wr_data;
    addr_t ram_rd_addr;
    word_t ram_rd_data;

    logic out_valid_reg, out_valid_next;
    res_t out_data_reg,  out_data_next;

    // unpack the command word, pad bits dropped
    assign req = req_t'(s_axis_tdata[$bits(req_t)-1:0]);

    isq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req         (req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    isq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_words (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register load and drain
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

// ===== sv/isq_checker.sv =====
// port-level checks on the indexed sequence store, bound to the top level
module isq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    import isq_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // status is always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == STAT_OK)
                       || (m_axis_tdata[1:0] == STAT_BOUNDS)
                       || (m_axis_tdata[1:0] == STAT_FULL))
        else $error("undefined status code");

    // a failed command reads back zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK) |-> m_axis_tdata[33:2] == '0)
        else $error("nonzero read value on failed command");

    // full is only reported with a full count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == STAT_FULL)
            |-> m_axis_tdata[39:34] == COUNT_W'(DEPTH))
        else $error("full status with count below depth");

endmodule

bind indexed_sequence_store isq_checker u_isq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/indexed_sequence_store_check.sv =====
// checker for the indexed sequence store: predicts each result word and compares it
module indexed_sequence_store_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // cmd[2:0], position_a[7:3], position_b[12:8], value[44:13], zero pad[47:45]
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], read_value[33:2], count[39:34]
    input  logic [39:0] m_axis_tdata,
    output int          mismatch_count,
    output int          results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import isq_pkg::*;

    localparam int PRINT_LIMIT = 40;

    // shadow copy of the sequence, position 0 is the head
    word_t seq_words [DEPTH];
    int    seq_count;
    res_t  expected_results [$];

    task automatic report_mismatch(input string what, input logic [39:0] want,
                                   input logic [39:0] got);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("%0t ns: mismatch in %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, want, got);
        end
        mismatch_count++;
    endtask

    // apply one command to the shadow sequence and return the result word it gives
    function automatic res_t apply_command(input req_t r);
        res_t  o;
        word_t held_word;
        int    pa;
        int    pb;
        o.status     = STAT_OK;
        o.read_value = '0;
        pa = int'(r.position_a);
        pb = int'(r.position_b);
        case (r.cmd)
            CMD_APPEND:
            begin
                if (seq_count >= DEPTH)
                begin
                    o.status = STAT_FULL;
                end
                else
                begin
                    seq_words[seq_count] = word_t'(r.value);
                    seq_count++;
                end
            end
            CMD_INSERT:
            begin
                if (seq_count >= DEPTH)
                begin
                    o.status = STAT_FULL;
                end
                else
                begin
                    for (int i = seq_count; i > 0; i--)
                    begin
                        seq_words[i] = seq_words[i-1];
                    end
                    seq_words[0] = word_t'(r.value);
                    seq_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (pa >= seq_count)
                begin
                    o.status = STAT_BOUNDS;
                end
                else
                begin
                    // later words close up
                    for (int i = pa; i + 1 < seq_count; i++)
                    begin
                        seq_words[i] = seq_words[i+1];
                    end
                    seq_count--;
                end
            end
            CMD_SWAP:
            begin
                if (pa >= seq_count || pb >= seq_count)
                begin
                    o.status = STAT_BOUNDS;
                end
                else
                begin
                    held_word     = seq_words[pa];
                    seq_words[pa] = seq_words[pb];
                    seq_words[pb] = held_word;
                end
            end
            CMD_READ:
            begin
                if (pa >= seq_count)
                begin
                    o.status = STAT_BOUNDS;
                end
                else
                begin
                    o.read_value = VALUE_W'(seq_words[pa]);
                end
            end
            default:
            begin
                o.status = STAT_BOUNDS;
            end
        endcase
        o.count = COUNT_W'(seq_count);
        return o;
    endfunction

    // watch both channels; results are checked before a new word is predicted
    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            seq_count = 0;
            expected_results.delete();
            mismatch_count  = 0;
            results_pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = res_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result word", '0, m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                    begin
                        report_mismatch("status", 40'(want.status), 40'(got.status));
                    end
                    if (got.read_value != want.read_value)
                    begin
                        report_mismatch("read_value", 40'(want.read_value),
                                        40'(got.read_value));
                    end
                    if (got.count != want.count)
                    begin
                        report_mismatch("count", 40'(want.count), 40'(got.count));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(apply_command(req_t'(s_axis_tdata[44:0])));
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

// ===== verif/indexed_sequence_store_test.sv =====
// testbench top for the indexed sequence store: clock, reset, command stimulus and verdict
module indexed_sequence_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    import isq_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BATCH_LEN      = 75;
    localparam int SETTLE_CYCLES  = 60;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    int mismatch_count;
    int results_pending;
    int send_idle_pct = 19;
    int recv_idle_pct = 69;
    int seq_len       = 0;
    int quiet_cycles  = 0;

    indexed_sequence_store u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    indexed_sequence_store_check u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // give up when no word moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // keep a rough length so positions mostly land inside the sequence
    function automatic void note_command(input req_t r);
        case (r.cmd)
            CMD_APPEND, CMD_INSERT:
            begin
                if (seq_len < DEPTH)
                begin
                    seq_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (int'(r.position_a) < seq_len)
                begin
                    seq_len--;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_command(input req_t r);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, r};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        note_command(r);
    endtask

    task automatic send_op(input cmd_t c, input int pa, input int pb, input logic [31:0] v);
        req_t r;
        r.cmd        = c;
        r.position_a = POS_W'(pa);
        r.position_b = POS_W'(pb);
        r.value      = v;
        send_command(r);
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [POS_W-1:0] pick_position();
        if (seq_len > 0 && $urandom_range(0, 99) < 85)
        begin
            return POS_W'($urandom_range(0, seq_len - 1));
        end
        return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return '0;
        end
        if (roll < 20)
        begin
            return '1;
        end
        return $urandom;
    endfunction

    // growing batches favour appends and inserts to fill the store, shrinking ones favour removes to drain it
    function automatic req_t random_command(input bit growing);
        req_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (growing)
        begin
            r.cmd = (roll < 35) ? CMD_APPEND : (roll < 70) ? CMD_INSERT :
                    (roll < 78) ? CMD_REMOVE : (roll < 89) ? CMD_SWAP : CMD_READ;
        end
        else
        begin
            r.cmd = (roll < 5) ? CMD_APPEND : (roll < 10) ? CMD_INSERT :
                    (roll < 75) ? CMD_REMOVE : (roll < 85) ? CMD_SWAP : CMD_READ;
        end
        r.position_a = pick_position();
        r.position_b = pick_position();
        r.value      = pick_value();
        return r;
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, small fills, self swap, removes at head, middle and tail
        send_op(CMD_READ,   0,  0,  32'h0);
        send_op(CMD_REMOVE, 0,  0,  32'h0);
        send_op(CMD_SWAP,   0,  0,  32'h0);
        send_op(CMD_APPEND, 0,  0,  32'h0000_0000);
        send_op(CMD_APPEND, 31, 31, 32'hFFFF_FFFF);
        send_op(CMD_INSERT, 0,  0,  32'hA5A5_A5A5);
        send_op(CMD_APPEND, 0,  0,  32'h1234_5678);
        send_op(CMD_READ,   0,  0,  32'h0);
        send_op(CMD_READ,   3,  0,  32'h0);
        send_op(CMD_READ,   4,  0,  32'h0);
        send_op(CMD_READ,   31, 0,  32'h0);
        send_op(CMD_SWAP,   1,  1,  32'h0);
        send_op(CMD_SWAP,   0,  3,  32'h0);
        send_op(CMD_READ,   0,  0,  32'h0);
        send_op(CMD_READ,   3,  0,  32'h0);
        send_op(CMD_SWAP,   0,  31, 32'h0);
        send_op(CMD_SWAP,   31, 0,  32'h0);
        send_op(CMD_REMOVE, 1,  0,  32'h0);
        send_op(CMD_REMOVE, 2,  0,  32'h0);
        send_op(CMD_REMOVE, 0,  0,  32'h0);
        send_op(CMD_READ,   0,  0,  32'h0);
        send_op(CMD_REMOVE, 31, 0,  32'h0);
        send_op(CMD_INSERT, 0,  0,  32'h5A5A_5A5A);
        drain_results();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 19 : 0;
            for (int batch = 0; batch < 4; batch++)
            begin
                for (int n = 0; n < BATCH_LEN; n++)
                begin
                    send_command(random_command(batch % 2 == 0));
                end
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
